// File: hw/rtl/alias_method_sampler_assert.svh
// ----------------------------------------------------------------------------
// alias_method_sampler_assert.svh
// Assertion macros for the alias-method sampler; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef ALIAS_METHOD_SAMPLER_ASSERT_SVH
`define ALIAS_METHOD_SAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
// check on clk, skipped while rst_n is low
`define AMS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("alias sampler check failed");
// check on clk, also active during reset
`define AMS_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("alias sampler reset check failed");
`else
`define AMS_ASSERT(lbl, prop)
`define AMS_ASSERT_RST(lbl, prop)
`endif
`endif

// File: hw/rtl/ams_pkg.sv
// ----------------------------------------------------------------------------
// ams_pkg
// Types and fixed constants of the alias-method sampler.
// ----------------------------------------------------------------------------
package ams_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int WEIGHT_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_BITS    = 10;
  localparam int CNT_BITS    = 11;
  localparam int SUM_BITS    = 26;
  localparam int SCALED_BITS = 28;
  localparam int KEEP_BITS   = 17;
  localparam int PROD_BITS   = WEIGHT_BITS + CNT_BITS;
  localparam int DVD_BITS    = PROD_BITS + FRAC_BITS;

  localparam logic [SCALED_BITS-1:0] ONE_SCALED = SCALED_BITS'(1) << FRAC_BITS;
  localparam logic [KEEP_BITS-1:0]   ONE_KEEP   = KEEP_BITS'(1) << FRAC_BITS;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  localparam logic [1:0] RDY_NONE  = 2'd0;
  localparam logic [1:0] RDY_BUILT = 2'd1;
  localparam logic [1:0] RDY_ZERO  = 2'd2;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_NOT_BUILT = 2'd1;
  localparam logic [1:0] ERR_RANGE     = 2'd2;
  localparam logic [1:0] ERR_ZERO      = 2'd3;

  typedef struct packed {
    logic                   cmd;
    logic [WEIGHT_BITS-1:0] weight;
    logic                   last;
    logic [IDX_BITS-1:0]    rand_index;
    logic [FRAC_BITS-1:0]   rand_frac;
  } in_item_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] sample_index;
    logic                took_alias;
    logic [1:0]          error;
  } out_item_t;

  typedef struct packed {
    logic [SCALED_BITS-1:0] scaled;
    logic [KEEP_BITS-1:0]   keep;
    logic [IDX_BITS-1:0]    alias_idx;
  } entry_t;

endpackage

// File: hw/rtl/ams_ram.sv
// ----------------------------------------------------------------------------
// ams_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ams_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/ams_div.sv
// ----------------------------------------------------------------------------
// ams_div
// Restoring divider, one quotient bit per cycle, done pulses at the end.
// ----------------------------------------------------------------------------
module ams_div #(
  parameter int DVD_W = 43,
  parameter int DVS_W = 26
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DVS_W:0]   rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DVS_W:0]   rem_sh;

  always_comb begin
    dvd_nxt  = dvd_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r[DVS_W-1:0], dvd_r[DVD_W-1]};
    if (start) begin
      dvd_nxt  = dividend;
      q_nxt    = '0;
      rem_nxt  = '0;
      cnt_nxt  = CW'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      dvs_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

// File: hw/rtl/alias_method_sampler.sv
// ----------------------------------------------------------------------------
// alias_method_sampler
// Walker alias-method sampler: weight load, table build and sample draw.
// ----------------------------------------------------------------------------
// Load: one transaction per cycle while not busy, written straight into the entry RAM.
// Sample: one transaction per cycle while not busy; result strobes in the cycle after accept.
// Build after the last weight holds busy through the sum pass, the scale pass
// (one divide per entry), the small/large pairing and the leftover writes.
// Reset is synchronous: counters and flags clear, RAM contents are left as is.
module alias_method_sampler (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  ams_pkg::in_item_t  in_item,
  output logic               out_valid,
  output ams_pkg::out_item_t out_item
);

  import ams_pkg::*;

  `include "alias_method_sampler_assert.svh"

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_ENTRIES);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  // build sequencer
  typedef enum logic [15:0] {
    ST_IDLE   = 16'h0001,
    ST_SUM    = 16'h0002,
    ST_SC_RD  = 16'h0004,
    ST_SC_MUL = 16'h0008,
    ST_SC_DIV = 16'h0010,
    ST_PR_CHK = 16'h0020,
    ST_PR_S   = 16'h0040,
    ST_PR_L   = 16'h0080,
    ST_PR_ES  = 16'h0100,
    ST_PR_EL  = 16'h0200,
    ST_PR_WL  = 16'h0400,
    ST_LO_CHK = 16'h0800,
    ST_LO_WR  = 16'h1000,
    ST_SPARE1 = 16'h2000,
    ST_SPARE2 = 16'h4000,
    ST_SPARE3 = 16'h8000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [1:0]             rdy_r, rdy_nxt;
  logic [CW-1:0]          n_r, n_nxt;
  logic [CW-1:0]          k_r, k_nxt;
  logic [CW-1:0]          ns_r, ns_nxt;
  logic [CW-1:0]          nl_r, nl_nxt;
  logic                   rvld_r, rvld_nxt;
  logic [SUM_BITS-1:0]    sum_r, sum_nxt;
  logic [IDX_BITS-1:0]    s_r, s_nxt;
  logic [IDX_BITS-1:0]    l_r, l_nxt;
  logic [SCALED_BITS-1:0] ps_r, ps_nxt;
  logic [SCALED_BITS-1:0] pl_r, pl_nxt;

  // sample stage
  logic                   smp_vld_r;
  logic [1:0]             smp_err_r;
  logic [IDX_BITS-1:0]    smp_idx_r;
  logic [FRAC_BITS-1:0]   smp_frac_r;

  // memories
  logic                   e_we;
  logic [AW-1:0]          e_waddr, e_raddr;
  entry_t                 e_wdata, e_rdata;
  logic                   s_we;
  logic [AW-1:0]          s_waddr, s_raddr;
  logic [IDX_BITS-1:0]    s_wdata, s_rdata;

  // divider
  logic                   dv_start;
  logic                   dv_done;
  logic [DVD_BITS-1:0]    dv_dividend, dv_quot;
  logic [PROD_BITS-1:0]   prod;
  logic [SCALED_BITS-1:0] q_scaled;

  logic                   accept;
  logic [CW-1:0]          cnt_eff;
  logic [1:0]             err_now;

  assign accept   = start && !busy;
  assign busy     = (state_r != ST_IDLE);
  assign prod     = PROD_BITS'(e_rdata.scaled[WEIGHT_BITS-1:0]) * PROD_BITS'(n_r);
  assign dv_dividend = {prod, {FRAC_BITS{1'b0}}};
  assign q_scaled = dv_quot[SCALED_BITS-1:0];

  // a load after a finished build starts a fresh weight set
  assign cnt_eff = (rdy_r != RDY_NONE) ? '0 : cnt_r;

  always_comb begin
    if (rdy_r == RDY_NONE) begin
      err_now = ERR_NOT_BUILT;
    end else if (rdy_r == RDY_ZERO) begin
      err_now = ERR_ZERO;
    end else if ({1'b0, in_item.rand_index} >= CNT_BITS'(cnt_r)) begin
      err_now = ERR_RANGE;
    end else begin
      err_now = ERR_OK;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rdy_nxt   = rdy_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    ns_nxt    = ns_r;
    nl_nxt    = nl_r;
    rvld_nxt  = 1'b0;
    sum_nxt   = sum_r;
    s_nxt     = s_r;
    l_nxt     = l_r;
    ps_nxt    = ps_r;
    pl_nxt    = pl_r;
    e_we      = 1'b0;
    e_waddr   = k_r[AW-1:0];
    e_wdata   = '0;
    e_raddr   = AW'(in_item.rand_index);
    s_we      = 1'b0;
    s_waddr   = ns_r[AW-1:0];
    s_wdata   = IDX_BITS'(k_r);
    s_raddr   = AW'(ns_r - ONE_C);
    dv_start  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (accept && in_item.cmd == CMD_LOAD) begin
          rdy_nxt = RDY_NONE;
          cnt_nxt = cnt_eff;
          // drop the weight when the store is full
          if (cnt_eff < MAX_C) begin
            e_we           = 1'b1;
            e_waddr        = cnt_eff[AW-1:0];
            e_wdata.scaled = SCALED_BITS'(in_item.weight);
            cnt_nxt        = cnt_eff + ONE_C;
          end
          if (in_item.last) begin
            n_nxt     = (cnt_eff < MAX_C) ? cnt_eff + ONE_C : cnt_eff;
            k_nxt     = '0;
            sum_nxt   = '0;
            state_nxt = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        // stream the weights out, one read per cycle
        e_raddr = k_r[AW-1:0];
        if (k_r < n_r) begin
          k_nxt    = k_r + ONE_C;
          rvld_nxt = 1'b1;
        end
        if (rvld_r) begin
          sum_nxt = sum_r + SUM_BITS'(e_rdata.scaled[WEIGHT_BITS-1:0]);
        end else if (k_r == n_r) begin
          if (sum_r == '0) begin
            rdy_nxt   = RDY_ZERO;
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = n_r - ONE_C;
            ns_nxt    = '0;
            nl_nxt    = '0;
            state_nxt = ST_SC_RD;
          end
        end
      end
      ST_SC_RD: begin
        e_raddr   = k_r[AW-1:0];
        state_nxt = ST_SC_MUL;
      end
      ST_SC_MUL: begin
        dv_start  = 1'b1;
        state_nxt = ST_SC_DIV;
      end
      ST_SC_DIV: begin
        if (dv_done) begin
          e_we           = 1'b1;
          e_waddr        = k_r[AW-1:0];
          e_wdata.scaled = q_scaled;
          // classify while scanning down: small grows up, large grows down
          s_we = 1'b1;
          if (q_scaled < ONE_SCALED) begin
            s_waddr = ns_r[AW-1:0];
            ns_nxt  = ns_r + ONE_C;
          end else begin
            s_waddr = AW'(MAX_C - nl_r - ONE_C);
            nl_nxt  = nl_r + ONE_C;
          end
          if (k_r == '0) begin
            state_nxt = ST_PR_CHK;
          end else begin
            k_nxt     = k_r - ONE_C;
            state_nxt = ST_SC_RD;
          end
        end
      end
      ST_PR_CHK: begin
        s_raddr = AW'(ns_r - ONE_C);
        if (ns_r != '0 && nl_r != '0) begin
          state_nxt = ST_PR_S;
        end else begin
          state_nxt = ST_LO_CHK;
        end
      end
      ST_PR_S: begin
        s_nxt     = s_rdata;
        s_raddr   = AW'(MAX_C - nl_r);
        state_nxt = ST_PR_L;
      end
      ST_PR_L: begin
        l_nxt     = s_rdata;
        e_raddr   = AW'(s_r);
        state_nxt = ST_PR_ES;
      end
      ST_PR_ES: begin
        ps_nxt    = e_rdata.scaled;
        e_raddr   = AW'(l_r);
        state_nxt = ST_PR_EL;
      end
      ST_PR_EL: begin
        // small entry is final; large one loses what the small one lacks
        pl_nxt            = e_rdata.scaled + ps_r - ONE_SCALED;
        e_we              = 1'b1;
        e_waddr           = AW'(s_r);
        e_wdata.scaled    = ps_r;
        e_wdata.keep      = ps_r[KEEP_BITS-1:0];
        e_wdata.alias_idx = l_r;
        ns_nxt            = ns_r - ONE_C;
        nl_nxt            = nl_r - ONE_C;
        state_nxt         = ST_PR_WL;
      end
      ST_PR_WL: begin
        e_we           = 1'b1;
        e_waddr        = AW'(l_r);
        e_wdata.scaled = pl_r;
        s_we           = 1'b1;
        s_wdata        = l_r;
        if (pl_r < ONE_SCALED) begin
          s_waddr = ns_r[AW-1:0];
          ns_nxt  = ns_r + ONE_C;
        end else begin
          s_waddr = AW'(MAX_C - nl_r - ONE_C);
          nl_nxt  = nl_r + ONE_C;
        end
        state_nxt = ST_PR_CHK;
      end
      ST_LO_CHK: begin
        // drain both stacks, each leftover keeps itself
        if (nl_r != '0) begin
          s_raddr   = AW'(MAX_C - nl_r);
          nl_nxt    = nl_r - ONE_C;
          state_nxt = ST_LO_WR;
        end else if (ns_r != '0) begin
          s_raddr   = AW'(ns_r - ONE_C);
          ns_nxt    = ns_r - ONE_C;
          state_nxt = ST_LO_WR;
        end else begin
          rdy_nxt   = RDY_BUILT;
          state_nxt = ST_IDLE;
        end
      end
      ST_LO_WR: begin
        e_we              = 1'b1;
        e_waddr           = AW'(s_rdata);
        e_wdata.keep      = ONE_KEEP;
        e_wdata.alias_idx = s_rdata;
        state_nxt         = ST_LO_CHK;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      rdy_r     <= RDY_NONE;
      n_r       <= '0;
      k_r       <= '0;
      ns_r      <= '0;
      nl_r      <= '0;
      rvld_r    <= 1'b0;
      smp_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      rdy_r     <= rdy_nxt;
      n_r       <= n_nxt;
      k_r       <= k_nxt;
      ns_r      <= ns_nxt;
      nl_r      <= nl_nxt;
      rvld_r    <= rvld_nxt;
      smp_vld_r <= accept && (in_item.cmd == CMD_SAMPLE);
    end
    sum_r      <= sum_nxt;
    s_r        <= s_nxt;
    l_r        <= l_nxt;
    ps_r       <= ps_nxt;
    pl_r       <= pl_nxt;
    smp_err_r  <= err_now;
    smp_idx_r  <= in_item.rand_index;
    smp_frac_r <= in_item.rand_frac;
  end

  // resolve the draw against the entry read issued at accept
  always_comb begin
    out_item = '0;
    out_item.error = smp_err_r;
    if (smp_err_r == ERR_OK) begin
      if ({1'b0, smp_frac_r} <= e_rdata.keep) begin
        out_item.sample_index = smp_idx_r;
      end else begin
        out_item.sample_index = e_rdata.alias_idx;
        out_item.took_alias   = 1'b1;
      end
    end
  end

  assign out_valid = smp_vld_r;

  ams_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_ENTRIES)
  ) u_entry_ram (
    .clk  (clk),
    .we   (e_we),
    .waddr(e_waddr),
    .wdata(e_wdata),
    .raddr(e_raddr),
    .rdata(e_rdata)
  );

  ams_ram #(
    .WIDTH(IDX_BITS),
    .DEPTH(MAX_ENTRIES)
  ) u_stack_ram (
    .clk  (clk),
    .we   (s_we),
    .waddr(s_waddr),
    .wdata(s_wdata),
    .raddr(s_raddr),
    .rdata(s_rdata)
  );

  ams_div #(
    .DVD_W(DVD_BITS),
    .DVS_W(SUM_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (dv_start),
    .dividend(dv_dividend),
    .divisor (sum_r),
    .done    (dv_done),
    .quotient(dv_quot)
  );

  logic stacks_fit;
  assign stacks_fit = ({1'b0, ns_r} + {1'b0, nl_r}) <= {1'b0, n_r};

  `AMS_ASSERT(a_out_after_sample, out_valid |-> $past(accept && in_item.cmd == CMD_SAMPLE))
  `AMS_ASSERT(a_last_starts_build, accept && in_item.cmd == CMD_LOAD && in_item.last |=> busy)
  `AMS_ASSERT(a_div_done_in_scale, dv_done |-> state_r == ST_SC_DIV)
  `AMS_ASSERT(a_stacks_fit, busy |-> stacks_fit)
  `AMS_ASSERT_RST(a_reset_quiet, !rst_n |=> !out_valid && !busy)

endmodule
